// File: sv/wls_pkg.sv
package wls_pkg;

	// Byte codes that end a word: every code above SEP_LO and below SEP_HI, newline, terminator
	localparam logic [7:0] SEP_LO   = 8'd31;
	localparam logic [7:0] SEP_HI   = 8'd65;
	localparam logic [7:0] CHAR_NL  = 8'd10;
	localparam logic [7:0] CHAR_NUL = 8'd0;

	// Width of the Q8.8 results and of the fraction bits of the variance
	localparam int Q_W    = 16;
	localparam int FRAC_W = 16;
	localparam int MFRAC_W = 8;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic byte_en;
		logic clear;
		logic mul_load;
		logic mul_step;
		logic div_load;
		logic div_step;
		logic mean_step;
		logic sqrt_load;
		logic sqrt_step;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic term;
	} dp_sts_t;

endpackage

// File: sv/wls_in_if.sv
interface wls_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

// File: sv/wls_out_if.sv
interface wls_out_if #(
	parameter int LEN_BITS   = 8,
	parameter int COUNT_BITS = 10
);
	logic                           valid;
	logic                           ready;
	logic [COUNT_BITS-1:0]          word_count;
	logic [LEN_BITS-1:0]            shortest;
	logic [LEN_BITS-1:0]            longest;
	logic [LEN_BITS+COUNT_BITS-1:0] total_length;
	logic [15:0]                    mean_q8;
	logic [15:0]                    stddev_q8;
	logic                           no_words;
	logic                           saturated;

	modport source (
		output valid, output word_count, output shortest, output longest,
		output total_length, output mean_q8, output stddev_q8, output no_words,
		output saturated, input ready
	);
	modport sink (
		input valid, input word_count, input shortest, input longest,
		input total_length, input mean_q8, input stddev_q8, input no_words,
		input saturated, output ready
	);
endinterface

// File: sv/wls_datapath.sv
module wls_datapath #(
	parameter int LEN_BITS   = 8,
	parameter int COUNT_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wls_pkg::dp_cmd_t               cmd,
	output wls_pkg::dp_sts_t               sts,
	input  logic [7:0]                     char_code,
	output logic [COUNT_BITS-1:0]          word_count,
	output logic [LEN_BITS-1:0]            shortest,
	output logic [LEN_BITS-1:0]            longest,
	output logic [LEN_BITS+COUNT_BITS-1:0] total_length,
	output logic [wls_pkg::Q_W-1:0]        mean_q8,
	output logic [wls_pkg::Q_W-1:0]        stddev_q8,
	output logic                           no_words,
	output logic                           saturated
);

	localparam int L      = LEN_BITS;
	localparam int C      = COUNT_BITS;
	localparam int SUM_W  = L + C;
	localparam int SQS_W  = 2 * L + C;
	localparam int PROD_W = 2 * L + 2 * C;
	localparam int MSQ_W  = 2 * C;
	localparam int DW     = PROD_W + wls_pkg::FRAC_W;
	localparam int VAR_W  = 2 * L + 15;
	localparam int MD_W   = SUM_W + wls_pkg::MFRAC_W;
	localparam int MQ_W   = L + wls_pkg::MFRAC_W;
	localparam int ROOT_W = L + 8;
	localparam int SQ_W   = 2 * ROOT_W;
	localparam int SRM_W  = L + 11;
	localparam int QW     = wls_pkg::Q_W;

	// Running statistics
	logic [L-1:0]     run_q;
	logic [C-1:0]     words_q;
	logic [L-1:0]     min_q;
	logic [L-1:0]     max_q;
	logic [SUM_W-1:0] sum_q;
	logic [SQS_W-1:0] sqs_q;
	logic             ovf_q;

	// Shift-add multipliers
	logic [SUM_W-1:0]  mn_q;
	logic [SUM_W-1:0]  ms_q;
	logic [PROD_W-1:0] acc1_q;
	logic [PROD_W-1:0] acc2_q;
	logic [MSQ_W-1:0]  acc3_q;

	// Restoring dividers
	logic [DW-1:0]    dvd_q;
	logic [MSQ_W-1:0] vr_q;
	logic [VAR_W-1:0] vq_q;
	logic [MD_W-1:0]  mdv_q;
	logic [C-1:0]     mr_q;
	logic [MQ_W-1:0]  mq_q;

	// Digit-by-digit square root
	logic [SQ_W-1:0]   sv_q;
	logic [ROOT_W-1:0] root_q;
	logic [SRM_W-1:0]  srem_q;

	// Result register
	logic [C-1:0]     res_count_q;
	logic [L-1:0]     res_short_q;
	logic [L-1:0]     res_long_q;
	logic [SUM_W-1:0] res_total_q;
	logic [QW-1:0]    res_mean_q;
	logic [QW-1:0]    res_sd_q;
	logic             res_none_q;
	logic             res_sat_q;

	logic             is_sep;
	logic [2*L-1:0]   run_sq;
	logic [MSQ_W:0]   vt;
	logic [C:0]       mt;
	logic [SRM_W-1:0] st;
	logic [SRM_W-1:0] trial;
	logic [MQ_W+QW-1:0]   mq_x;
	logic [ROOT_W+QW-1:0] root_x;
	logic             have_words;

	// Classify the byte
	assign is_sep = ((char_code > wls_pkg::SEP_LO) && (char_code < wls_pkg::SEP_HI)) ||
		(char_code == wls_pkg::CHAR_NL) || (char_code == wls_pkg::CHAR_NUL);
	assign sts.term = (char_code == wls_pkg::CHAR_NUL);
	assign run_sq = run_q * run_q;

	// Update the statistics per byte, clear them when a result is captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			words_q <= '0;
			min_q   <= '1;
			max_q   <= '0;
			sum_q   <= '0;
			sqs_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.clear) begin
			run_q   <= '0;
			words_q <= '0;
			min_q   <= '1;
			max_q   <= '0;
			sum_q   <= '0;
			sqs_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.byte_en) begin
			if (is_sep) begin
				run_q <= '0;
				if (run_q != '0) begin
					if (&words_q) begin
						ovf_q <= 1'b1;
					end else begin
						words_q <= words_q + 1'b1;
						if (run_q < min_q)
							min_q <= run_q;
						if (run_q > max_q)
							max_q <= run_q;
						sum_q <= sum_q + SUM_W'(run_q);
						sqs_q <= sqs_q + SQS_W'(run_sq);
					end
				end
			end else if (&run_q) begin
				ovf_q <= 1'b1;
			end else begin
				run_q <= run_q + 1'b1;
			end
		end
	end

	// Step terms of the dividers and of the square root
	assign vt    = {vr_q, dvd_q[DW-1]};
	assign mt    = {mr_q, mdv_q[MD_W-1]};
	assign st    = {srem_q[SRM_W-3:0], sv_q[SQ_W-1 -: 2]};
	assign trial = SRM_W'({root_q, 2'b01});

	// Multiply, divide and take the root, one bit or digit a cycle
	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			mn_q   <= SUM_W'(words_q);
			ms_q   <= sum_q;
			acc1_q <= '0;
			acc2_q <= '0;
			acc3_q <= '0;
		end else if (cmd.mul_step) begin
			mn_q   <= mn_q << 1;
			ms_q   <= ms_q << 1;
			acc1_q <= (acc1_q << 1) + (mn_q[SUM_W-1] ? PROD_W'(sqs_q) : '0);
			acc2_q <= (acc2_q << 1) + (ms_q[SUM_W-1] ? PROD_W'(sum_q) : '0);
			acc3_q <= (acc3_q << 1) + (mn_q[SUM_W-1] ? MSQ_W'(words_q) : '0);
		end

		if (cmd.div_load) begin
			dvd_q <= {acc1_q - acc2_q, {wls_pkg::FRAC_W{1'b0}}};
			vr_q  <= '0;
			vq_q  <= '0;
			mdv_q <= {sum_q, {wls_pkg::MFRAC_W{1'b0}}};
			mr_q  <= '0;
			mq_q  <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			if (vt >= {1'b0, acc3_q}) begin
				vr_q <= MSQ_W'(vt - {1'b0, acc3_q});
				vq_q <= {vq_q[VAR_W-2:0], 1'b1};
			end else begin
				vr_q <= MSQ_W'(vt);
				vq_q <= {vq_q[VAR_W-2:0], 1'b0};
			end
			if (cmd.mean_step) begin
				mdv_q <= mdv_q << 1;
				if (mt >= {1'b0, words_q}) begin
					mr_q <= C'(mt - {1'b0, words_q});
					mq_q <= {mq_q[MQ_W-2:0], 1'b1};
				end else begin
					mr_q <= C'(mt);
					mq_q <= {mq_q[MQ_W-2:0], 1'b0};
				end
			end
		end

		if (cmd.sqrt_load) begin
			sv_q   <= SQ_W'(vq_q);
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sqrt_step) begin
			sv_q <= sv_q << 2;
			if (st >= trial) begin
				srem_q <= st - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= st;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	// Saturate mean and deviation to the Q8.8 range
	assign have_words = (words_q != '0);
	assign mq_x   = {{QW{1'b0}}, mq_q};
	assign root_x = {{QW{1'b0}}, root_q};

	// Capture the result
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_count_q <= words_q;
			res_short_q <= have_words ? min_q : '0;
			res_long_q  <= have_words ? max_q : '0;
			res_total_q <= sum_q;
			res_none_q  <= !have_words;
			res_sat_q   <= ovf_q;
			if (!have_words)
				res_mean_q <= '0;
			else if (mq_x[MQ_W+QW-1:QW] != '0)
				res_mean_q <= '1;
			else
				res_mean_q <= mq_x[QW-1:0];
			if (!have_words)
				res_sd_q <= '0;
			else if (root_x[ROOT_W+QW-1:QW] != '0)
				res_sd_q <= '1;
			else
				res_sd_q <= root_x[QW-1:0];
		end
	end

	assign word_count   = res_count_q;
	assign shortest     = res_short_q;
	assign longest      = res_long_q;
	assign total_length = res_total_q;
	assign mean_q8      = res_mean_q;
	assign stddev_q8    = res_sd_q;
	assign no_words     = res_none_q;
	assign saturated    = res_sat_q;

endmodule

// File: sv/wls_controller.sv
module wls_controller #(
	parameter int LEN_BITS   = 8,
	parameter int COUNT_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  wls_pkg::dp_sts_t  sts,
	output wls_pkg::dp_cmd_t  cmd
);

	localparam int SUM_W  = LEN_BITS + COUNT_BITS;
	localparam int DW     = 2 * LEN_BITS + 2 * COUNT_BITS + wls_pkg::FRAC_W;
	localparam int MD_W   = SUM_W + wls_pkg::MFRAC_W;
	localparam int ROOT_W = LEN_BITS + 8;
	localparam int CNT_W  = $clog2(DW + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SQRT,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic               accept;
	logic               out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Decode commands from state and step count
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.byte_en = accept;
			end
			ST_MUL: begin
				cmd.mul_load = (cnt_q == '0);
				cmd.mul_step = (cnt_q != '0);
			end
			ST_DIV: begin
				cmd.div_load  = (cnt_q == '0);
				cmd.div_step  = (cnt_q != '0);
				cmd.mean_step = (cnt_q != '0) && (cnt_q <= CNT_W'(MD_W));
			end
			ST_SQRT: begin
				cmd.sqrt_load = (cnt_q == '0);
				cmd.sqrt_step = (cnt_q != '0);
			end
			ST_EMIT: begin
				cmd.emit  = out_free;
				cmd.clear = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Sequence the phases and hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_EMIT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && sts.term)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (cnt_q == CNT_W'(SUM_W)) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DW)) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == CNT_W'(ROOT_W)) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/word_length_statistics_core.sv
// Channel | Dir | Handshake     | Payload
// text    | in  | valid / ready | char_code
// stats   | out | valid / ready | word_count, shortest, longest, total_length,
//         |     |               | mean_q8, stddev_q8, no_words, saturated
//
// Text bytes other than the terminator stream back to back while the block is idle.
// After the terminator, text.ready stays low through the multiply, divide, root and
// emit phases; stats.valid rises as the result is captured in the result register.
// The result register lets the next sentence stream in while a result waits;
// a second result holds text.ready low until the register empties.
// Reset (arst_n low) clears the running statistics and drops stats.valid.
module word_length_statistics_core #(
	parameter int LEN_BITS   = 8,
	parameter int COUNT_BITS = 10
) (
	input logic         clk,
	input logic         arst_n,
	wls_in_if.sink      text,
	wls_out_if.source   stats
);

	wls_pkg::dp_cmd_t cmd;
	wls_pkg::dp_sts_t sts;

	// Sequence the sentence and result transactions
	wls_controller #(
		.LEN_BITS   (LEN_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (text.valid),
		.in_ready  (text.ready),
		.out_valid (stats.valid),
		.out_ready (stats.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Gather statistics and work out mean and deviation
	wls_datapath #(
		.LEN_BITS   (LEN_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.char_code    (text.char_code),
		.word_count   (stats.word_count),
		.shortest     (stats.shortest),
		.longest      (stats.longest),
		.total_length (stats.total_length),
		.mean_q8      (stats.mean_q8),
		.stddev_q8    (stats.stddev_q8),
		.no_words     (stats.no_words),
		.saturated    (stats.saturated)
	);

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int LEN_BITS   = 8;
	localparam int COUNT_BITS = 10;
	localparam int SUM_BITS   = LEN_BITS + COUNT_BITS;
	localparam int unsigned LEN_MAX   = (1 << LEN_BITS) - 1;
	localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
	localparam longint unsigned Q_MAX = (64'd1 << wls_pkg::Q_W) - 1;

	localparam int unsigned CLK_HALF     = 2;
	localparam int unsigned RANDOM_BYTES = 1320;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned TAIL_CYCLES  = 80;
	localparam longint unsigned CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		logic [COUNT_BITS-1:0]   word_count;
		logic [LEN_BITS-1:0]     shortest;
		logic [LEN_BITS-1:0]     longest;
		logic [SUM_BITS-1:0]     total_length;
		logic [wls_pkg::Q_W-1:0] mean_q8;
		logic [wls_pkg::Q_W-1:0] stddev_q8;
		logic                    no_words;
		logic                    saturated;
	} stats_t;

	// Track sentence statistics and hold the results still owed by the block
	class stats_scoreboard;
		int unsigned run_len;
		int unsigned words;
		int unsigned min_len;
		int unsigned max_len;
		longint unsigned len_sum;
		longint unsigned sq_sum;
		bit overflow;
		stats_t pending_stats[$];
		int unsigned errors;

		function new();
			clear_sentence();
			errors = 0;
		endfunction

		function bit is_break(logic [7:0] c);
			return (c > wls_pkg::SEP_LO && c < wls_pkg::SEP_HI) || c == wls_pkg::CHAR_NL ||
				c == wls_pkg::CHAR_NUL;
		endfunction

		function void clear_sentence();
			run_len  = 0;
			words    = 0;
			min_len  = LEN_MAX;
			max_len  = 0;
			len_sum  = 0;
			sq_sum   = 0;
			overflow = 1'b0;
		endfunction

		// Fold a finished word into the totals; empty words leave no trace
		function void close_word();
			int unsigned len;
			len = run_len;
			run_len = 0;
			if (len == 0)
				return;
			if (words >= COUNT_MAX) begin
				overflow = 1'b1;
				return;
			end
			words++;
			if (len < min_len)
				min_len = len;
			if (len > max_len)
				max_len = len;
			len_sum += len;
			sq_sum  += len * len;
		endfunction

		function longint unsigned floor_root(longint unsigned v);
			longint unsigned root;
			longint unsigned step;
			root = 0;
			step = 64'h4000_0000_0000_0000;
			while (step > v)
				step >>= 2;
			while (step != 0) begin
				if (v >= root + step) begin
					v -= root + step;
					root = (root >> 1) + step;
				end else begin
					root >>= 1;
				end
				step >>= 2;
			end
			return root;
		endfunction

		// Advance the statistics by one accepted byte; a terminator owes one result
		function void note_byte(logic [7:0] c);
			stats_t e;
			longint unsigned n, m, d, q, r, mean, dev;
			if (is_break(c))
				close_word();
			else if (run_len >= LEN_MAX)
				overflow = 1'b1;
			else
				run_len++;
			if (c != wls_pkg::CHAR_NUL)
				return;
			n = words;
			mean = 0;
			dev = 0;
			if (n != 0) begin
				m = n * n;
				d = n * sq_sum - len_sum * len_sum;
				q = d / m;
				r = d % m;
				dev = floor_root((q << wls_pkg::FRAC_W) + ((r << wls_pkg::FRAC_W) / m));
				mean = (len_sum << wls_pkg::MFRAC_W) / n;
				if (mean > Q_MAX)
					mean = Q_MAX;
				if (dev > Q_MAX)
					dev = Q_MAX;
			end
			e.word_count   = COUNT_BITS'(n);
			e.shortest     = (n != 0) ? LEN_BITS'(min_len) : '0;
			e.longest      = (n != 0) ? LEN_BITS'(max_len) : '0;
			e.total_length = SUM_BITS'(len_sum);
			e.mean_q8      = wls_pkg::Q_W'(mean);
			e.stddev_q8    = wls_pkg::Q_W'(dev);
			e.no_words     = (n == 0);
			e.saturated    = overflow;
			pending_stats.push_back(e);
			clear_sentence();
		endfunction

		function void compare_field(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		// Match a stats transaction against the oldest owed result
		function void check_result(stats_t got);
			stats_t e;
			if (pending_stats.size() == 0) begin
				$error("stats transaction with no result outstanding");
				errors++;
				return;
			end
			e = pending_stats.pop_front();
			compare_field("word_count", 64'(e.word_count), 64'(got.word_count));
			compare_field("shortest", 64'(e.shortest), 64'(got.shortest));
			compare_field("longest", 64'(e.longest), 64'(got.longest));
			compare_field("total_length", 64'(e.total_length), 64'(got.total_length));
			compare_field("mean_q8", 64'(e.mean_q8), 64'(got.mean_q8));
			compare_field("stddev_q8", 64'(e.stddev_q8), 64'(got.stddev_q8));
			compare_field("no_words", 64'(e.no_words), 64'(got.no_words));
			compare_field("saturated", 64'(e.saturated), 64'(got.saturated));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	wls_in_if text_if ();
	wls_out_if #(.LEN_BITS(LEN_BITS), .COUNT_BITS(COUNT_BITS)) stats_if ();

	word_length_statistics_core #(
		.LEN_BITS  (LEN_BITS),
		.COUNT_BITS(COUNT_BITS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.text  (text_if),
		.stats (stats_if)
	);

	stats_scoreboard sb = new();
	bit              idle_on = 1'b0;
	int unsigned     idle_odds = 4;
	bit              long_hold_req = 1'b0;
	int unsigned     bytes_sent = 0;
	longint unsigned cycle_count = 0;

	always #(CLK_HALF) clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL word_length_statistics_core");
			$finish;
		end
	end

	// Check every stats transaction
	always @(posedge clk) begin
		if (arst_n && stats_if.valid && stats_if.ready)
			sb.check_result(stats_t'{stats_if.word_count, stats_if.shortest, stats_if.longest,
				stats_if.total_length, stats_if.mean_q8, stats_if.stddev_q8,
				stats_if.no_words, stats_if.saturated});
	end

	// Drive stats.ready: long hold on request, random stall bursts while idle_on is set
	initial begin
		stats_if.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				stats_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				stats_if.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				stats_if.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Offer one byte, with an occasional gap first, and hold it until accepted
	task automatic send_byte(input logic [7:0] c);
		if (idle_on && $urandom_range(0, idle_odds) == 0) begin
			text_if.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		text_if.valid     <= 1'b1;
		text_if.char_code <= c;
		do @(posedge clk); while (!text_if.ready);
		sb.note_byte(c);
		bytes_sent++;
	endtask

	function automatic logic [7:0] pick_letter();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255)); while (sb.is_break(c));
		return c;
	endfunction

	function automatic logic [7:0] pick_break();
		if ($urandom_range(0, 7) == 0)
			return wls_pkg::CHAR_NL;
		return 8'($urandom_range(wls_pkg::SEP_LO + 1, wls_pkg::SEP_HI - 1));
	endfunction

	task automatic send_word(input int unsigned len);
		repeat (len) send_byte(pick_letter());
	endtask

	// Send words of random length, sometimes with empty words, then the terminator
	task automatic send_sentence(input int unsigned n_words, input int unsigned max_len);
		for (int unsigned i = 0; i < n_words; i++) begin
			if ($urandom_range(0, 5) == 0)
				send_byte(pick_break());
			send_word($urandom_range(1, max_len));
			if (i != n_words - 1 || $urandom_range(0, 1) == 0)
				send_byte(pick_break());
		end
		send_byte(wls_pkg::CHAR_NUL);
	endtask

	// Pause the sender until every owed result has arrived
	task automatic drain();
		text_if.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_stats.size() != 0);
	endtask

	initial begin
		int unsigned start;
		int unsigned progress;
		int unsigned sentences;
		int unsigned kind;
		bit hold_done;

		arst_n            = 1'b0;
		text_if.valid     = 1'b0;
		text_if.char_code = '0;
		sentences = 0;
		hold_done = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty sentences, edge bytes and long words
		idle_on   = 1'b1;
		idle_odds = 3;
		send_byte(wls_pkg::CHAR_NUL);
		send_byte(8'd32);
		send_byte(8'd64);
		send_byte(wls_pkg::CHAR_NL);
		send_byte(wls_pkg::CHAR_NUL);
		send_byte(8'd31);
		send_byte(8'd65);
		send_byte(wls_pkg::CHAR_NUL);
		send_byte(8'd1);
		send_byte(8'd9);
		send_byte(8'd11);
		send_byte(8'd127);
		send_byte(8'd128);
		send_byte(8'd255);
		send_byte(8'd64);
		send_byte(8'hAA);
		send_byte(8'h55);
		send_byte(wls_pkg::CHAR_NUL);
		send_word(LEN_MAX);
		send_byte(wls_pkg::CHAR_NUL);
		send_word(LEN_MAX + 1);
		send_byte(8'd33);
		send_word(2);
		send_byte(wls_pkg::CHAR_NUL);
		drain();

		// Random sentences, with noise, one long receiver hold and periodic drains
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			progress  = bytes_sent - start;
			idle_on   = progress < RANDOM_BYTES * 4 / 5;
			idle_odds = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(1, 6);
			if (!hold_done && progress >= RANDOM_BYTES / 4) begin
				hold_done     = 1'b1;
				long_hold_req = 1'b1;
				idle_on       = 1'b0;
				repeat (10) send_sentence(2, 3);
			end else if (sentences % 16 == 15) begin
				drain();
			end
			kind = $urandom_range(0, 19);
			case (kind)
				0: begin
					repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
					send_byte(wls_pkg::CHAR_NUL);
				end
				1: send_sentence($urandom_range(1, 3), 300);
				2: send_sentence(0, 1);
				default: send_sentence($urandom_range(0, 12), $urandom_range(1, 12));
			endcase
			sentences++;
		end

		// Wait for every owed result, then let the block settle
		text_if.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_stats.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_stats.size() == 0)
			$display("PASS word_length_statistics_core");
		else
			$display("FAIL word_length_statistics_core");
		$finish;
	end

endmodule
